[rtl/core/single_wire_sensor_pulse_receiver_defines.svh]
// assertion macros shared by the checker file of the pulse receiver
`ifndef SINGLE_WIRE_SENSOR_PULSE_RECEIVER_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_PULSE_RECEIVER_DEFINES_SVH

// same-cycle implication, masked while in reset
`define SWSP_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, masked while in reset
`define SWSP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// next-cycle implication that also covers reset itself
`define SWSP_ASSERT_ALWAYS(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/swsp_pkg.sv]
// shared constants and types of the single-wire sensor pulse receiver
package swsp_pkg;

  localparam int FRAME_BITS  = 40;
  localparam int BIT_COUNT_W = 6;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // action codes of an input item
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_EDGE   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM    = 2'd1;
  localparam logic [1:0] STATUS_PULSE_ERR  = 2'd2;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd3;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_PRE_BIT  = 2'd0;
  localparam logic [1:0] REG_ZERO_MAX = 2'd1;
  localparam logic [1:0] REG_ONE_MAX  = 2'd2;

  localparam logic [7:0] PRE_BIT_RESET  = 8'd50;
  localparam logic [7:0] ZERO_MAX_RESET = 8'd38;
  localparam logic [7:0] ONE_MAX_RESET  = 8'd80;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] humid_whole;
    logic [7:0] humid_frac;
    logic [7:0] temp_whole;
    logic [7:0] temp_frac;
    logic [7:0] sum_received;
    logic [7:0] sum_computed;
  } result_t;

endpackage

[rtl/core/single_wire_sensor_pulse_receiver.sv]
// single-wire sensor pulse receiver: decodes a 40-bit humidity/temperature frame
//
//   channel  direction  handshake            payload
//   in       inbound    in_valid / in_stall  action, edge_time_us, late_level
//   out      outbound   out_valid / out_stall status, five frame bytes, sum_computed
//   cfg      inbound    apb write / read     pre_bit_delay_us, zero_max_us, one_max_us
//
// one item is taken every cycle while in_stall is low; its result, if any, is
// registered. the decode is a subtract, two limit adds, two compares, a bit set
// and the checksum sum between the state registers and the result register.
// a one-entry skid stage behind the result register absorbs a result while out is
// stalled; in_stall rises only while that skid entry is full.
// rst is synchronous: phase idle, empty frame, both result stages empty, config registers back to defaults.
module single_wire_sensor_pulse_receiver (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [31:0]                 edge_time_us,
  input  logic                        late_level,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [7:0]                  humid_whole,
  output logic [7:0]                  humid_frac,
  output logic [7:0]                  temp_whole,
  output logic [7:0]                  temp_frac,
  output logic [7:0]                  sum_received,
  output logic [7:0]                  sum_computed,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swsp_pkg::ADDR_W-1:0] paddr,
  input  logic [swsp_pkg::DATA_W-1:0] pwdata,
  output logic [swsp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ACK1,
    PH_ACK2,
    PH_BITS,
    PH_ERR
  } phase_t;

  phase_t                              phase, phase_next;
  logic [swsp_pkg::BIT_COUNT_W-1:0]    bit_count, bit_count_next;
  logic [31:0]                         last_edge_time, last_edge_time_next;
  logic [swsp_pkg::FRAME_BITS-1:0]     frame_bits, frame_bits_next;

  logic [7:0] pre_bit_delay_us;
  logic [7:0] zero_max_us;
  logic [7:0] one_max_us;

  swsp_pkg::result_t out_res, skid_res, res;
  logic              skid_full;
  logic              res_valid;

  logic        in_fire;
  logic        out_fire;
  logic        cfg_write;
  logic [31:0] gap;
  logic [8:0]  zero_limit;
  logic [8:0]  one_limit;
  logic [swsp_pkg::BIT_COUNT_W-1:0] bit_pos;

  function automatic swsp_pkg::result_t build_result(
    input phase_t                          ph,
    input logic [swsp_pkg::FRAME_BITS-1:0] f
  );
    swsp_pkg::result_t r;
    r.humid_whole  = f[39:32];
    r.humid_frac   = f[31:24];
    r.temp_whole   = f[23:16];
    r.temp_frac    = f[15:8];
    r.sum_received = f[7:0];
    r.sum_computed = 8'(f[39:32] + f[31:24] + f[23:16] + f[15:8]);
    if (ph == PH_ERR) begin
      r.status = swsp_pkg::STATUS_PULSE_ERR;
    end else if (ph != PH_IDLE) begin
      r.status = swsp_pkg::STATUS_INCOMPLETE;
    end else if (r.sum_received == r.sum_computed && r.humid_whole != 8'd0
                 && r.temp_whole != 8'd0) begin
      r.status = swsp_pkg::STATUS_OK;
    end else begin
      r.status = swsp_pkg::STATUS_BAD_SUM;
    end
    return r;
  endfunction

  assign in_stall  = skid_full;
  assign in_fire   = in_valid && !skid_full;
  assign out_fire  = out_valid && !out_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // high time = gap - pre_bit_delay, so compare the gap against delay + limit
  assign gap        = edge_time_us - last_edge_time;
  assign zero_limit = {1'b0, pre_bit_delay_us} + {1'b0, zero_max_us};
  assign one_limit  = {1'b0, pre_bit_delay_us} + {1'b0, one_max_us};
  // frame index bit_count-1 sits at vector position FRAME_BITS-bit_count
  assign bit_pos    = swsp_pkg::BIT_COUNT_W'(swsp_pkg::FRAME_BITS) - bit_count;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    last_edge_time_next = last_edge_time;
    frame_bits_next     = frame_bits;
    res_valid           = 1'b0;
    if (in_fire) begin
      case (action)
        swsp_pkg::ACT_START: begin
          phase_next          = PH_ACK1;
          bit_count_next      = '0;
          last_edge_time_next = '0;
          frame_bits_next     = '0;
        end
        swsp_pkg::ACT_EDGE: begin
          case (phase)
            PH_ACK1: phase_next = PH_ACK2;
            PH_ACK2: phase_next = PH_BITS;
            PH_BITS: begin
              last_edge_time_next = edge_time_us;
              if (bit_count == '0) begin
                bit_count_next = swsp_pkg::BIT_COUNT_W'(1);
              end else if (gap > {23'd0, one_limit} && gap > {23'd0, zero_limit}) begin
                phase_next = PH_ERR;
                res_valid  = 1'b1;
              end else begin
                if (gap > {23'd0, zero_limit}) begin
                  frame_bits_next[bit_pos] = 1'b1;
                end
                bit_count_next = bit_count + 1'b1;
                if (bit_count == swsp_pkg::BIT_COUNT_W'(swsp_pkg::FRAME_BITS - 1)) begin
                  // last bit comes from the late line sample
                  if (late_level) begin
                    frame_bits_next[0] = 1'b1;
                  end
                  phase_next = PH_IDLE;
                  res_valid  = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        swsp_pkg::ACT_FINISH: res_valid = 1'b1;
        default: ;
      endcase
    end
    res = build_result(phase_next, frame_bits_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_count        <= '0;
      last_edge_time   <= '0;
      frame_bits       <= '0;
      out_valid        <= 1'b0;
      skid_full        <= 1'b0;
      pre_bit_delay_us <= swsp_pkg::PRE_BIT_RESET;
      zero_max_us      <= swsp_pkg::ZERO_MAX_RESET;
      one_max_us       <= swsp_pkg::ONE_MAX_RESET;
    end else begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      last_edge_time <= last_edge_time_next;
      frame_bits     <= frame_bits_next;

      if (skid_full) begin
        if (out_fire) begin
          out_res   <= skid_res;
          skid_full <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid || out_fire) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_res  <= res;
          skid_full <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (paddr[3:2])
          swsp_pkg::REG_PRE_BIT:  pre_bit_delay_us <= pwdata[7:0];
          swsp_pkg::REG_ZERO_MAX: zero_max_us      <= pwdata[7:0];
          swsp_pkg::REG_ONE_MAX:  one_max_us       <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      swsp_pkg::REG_PRE_BIT:  prdata = {24'd0, pre_bit_delay_us};
      swsp_pkg::REG_ZERO_MAX: prdata = {24'd0, zero_max_us};
      swsp_pkg::REG_ONE_MAX:  prdata = {24'd0, one_max_us};
      default:                prdata = '0;
    endcase
  end

  assign status       = out_res.status;
  assign humid_whole  = out_res.humid_whole;
  assign humid_frac   = out_res.humid_frac;
  assign temp_whole   = out_res.temp_whole;
  assign temp_frac    = out_res.temp_frac;
  assign sum_received = out_res.sum_received;
  assign sum_computed = out_res.sum_computed;

endmodule

[rtl/core/swsp_checker.sv]
// port-level checker for the pulse receiver, bound to the top level
`include "single_wire_sensor_pulse_receiver_defines.svh"

module swsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [7:0] humid_whole,
  input logic [7:0] temp_whole,
  input logic [7:0] sum_received,
  input logic [7:0] sum_computed
);

  logic out_blocked;
  logic ok_out;
  logic frame_checks;

  assign out_blocked  = out_valid && out_stall;
  assign ok_out       = out_valid && status == swsp_pkg::STATUS_OK;
  assign frame_checks = sum_received == sum_computed && humid_whole != 8'd0
                        && temp_whole != 8'd0;

  // reset leaves both result stages empty
  `SWSP_ASSERT_ALWAYS(a_reset_empty, rst, !out_valid && !in_stall, "stages not empty after reset")

  // input only stalls when the skid holds a result behind a full output
  `SWSP_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid, "input stalled with no result pending")

  // the skid fills only when a result was blocked at the output
  `SWSP_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_blocked), "stall without a blocked result")

  // a good status means the checksum and the whole bytes really check out
  `SWSP_ASSERT_NOW(a_ok_status, ok_out, frame_checks, "good status on a frame that fails its check")

  // a stalled result holds its status
  `SWSP_ASSERT_NEXT(a_out_hold, out_blocked, out_valid && $stable(status), "stalled result changed")

endmodule

bind single_wire_sensor_pulse_receiver swsp_checker u_swsp_checker (.*);
